// ----- hdl/fasr_pkg.sv -----
`default_nettype none
package fasr_pkg;
   localparam int unsigned NUM_DEST = 5;
   localparam int unsigned POS_W = 16;
   localparam int unsigned MASK_W = 6;
   localparam logic [15:0] STEP_PERIOD_RESET = 16'd3174;
   localparam logic [15:0] SETTLE_EXTRA_RESET = 16'd614;
   localparam int unsigned MIRROR_BIT = 5;
   localparam int unsigned MIRROR_SRC = 1;

   typedef enum logic [0:0] {
      REQ_TICK = 1'b0,
      REQ_MOVE = 1'b1
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_STEP_PERIOD = 1'b0,
      CSR_SETTLE_EXTRA = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        req_type;
      logic [15:0] dest_0;
      logic [15:0] dest_1;
      logic [15:0] dest_2;
      logic [15:0] dest_3;
      logic [15:0] dest_4;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] pos_0;
      logic [15:0] pos_1;
      logic [15:0] pos_2;
      logic [15:0] pos_3;
      logic [15:0] pos_4;
      logic [5:0]  write_mask;
      logic        busy_res;
   } rsp_payload_type;

   // Command from the sequencer to every lane.
   typedef struct packed {
      logic        load;       // latch target and difference
      logic        div_start;  // begin the interval division
      logic        tick;       // evaluate a step
      logic [31:0] tick_count; // tick count after increment
      logic [31:0] dividend;   // largest_diff * step_period
   } lane_cmd_type;

   // Status from one lane back to the sequencer.
   typedef struct packed {
      logic        div_busy;
      logic        done;
      logic        wrote;
      logic [15:0] diff;
      logic [15:0] pos;
   } lane_stat_type;
endpackage
`default_nettype wire

// ----- hdl/fasr_lane.sv -----
`default_nettype none
module fasr_lane
   import fasr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lane_cmd_type  cmd,
   input  wire logic [15:0]   dest,
   output lane_stat_type      stat
);
   logic [15:0] cur_ff, cur_in;
   logic [15:0] tgt_ff, tgt_in;
   logic        up_ff, up_in;
   logic [15:0] diff_ff, diff_in;
   logic [31:0] iv_ff, iv_in;
   logic [31:0] last_ff, last_in;
   // Restoring divider: quotient shifts into rem/quo pair one bit a cycle.
   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] rem_sh;
   logic [39:0] t_q8;
   logic [33:0] iv2, iv3;
   logic [1:0]  n;
   logic        fire;
   logic [16:0] up_sum;
   logic [15:0] step_pos;

   always_comb begin
      t_q8 = {(cmd.tick_count - last_ff), 8'd0};
      iv2 = {1'b0, iv_ff, 1'b0};
      iv3 = iv2 + {2'd0, iv_ff};
      fire = cmd.tick && (iv_ff != 32'd0) && (tgt_ff != 16'd0) && (t_q8 >= {8'd0, iv_ff});
      if (t_q8 >= {6'd0, iv3}) n = 2'd3;
      else if (t_q8 >= {6'd0, iv2}) n = 2'd2;
      else n = 2'd1;
      up_sum = {1'b0, cur_ff} + {15'd0, n};
      if (up_ff) begin
         step_pos = (up_sum > {1'b0, tgt_ff}) ? tgt_ff : up_sum[15:0];
      end else begin
         if ((cur_ff < {14'd0, n}) || ((cur_ff - {14'd0, n}) < tgt_ff)) step_pos = tgt_ff;
         else step_pos = cur_ff - {14'd0, n};
      end
      rem_sh = {rem_ff[15:0], quo_ff[31]};
   end

   always_comb begin
      cur_in = cur_ff; tgt_in = tgt_ff; up_in = up_ff; diff_in = diff_ff;
      iv_in = iv_ff; last_in = last_ff; quo_in = quo_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      if (cmd.load) begin
         tgt_in = dest;
         up_in = dest > cur_ff;
         diff_in = (dest > cur_ff) ? dest - cur_ff : cur_ff - dest;
         last_in = cmd.tick_count;
      end
      if (cmd.div_start) begin
         if (diff_ff == 16'd0) begin
            iv_in = 32'd0;
         end else begin
            quo_in = cmd.dividend; rem_in = 17'd0; cnt_in = 6'd32; busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, diff_ff}) begin
            rem_in = rem_sh - {1'b0, diff_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            iv_in = ({quo_ff[30:0], rem_sh >= {1'b0, diff_ff}} == 32'd0) ? 32'd1
                  : {quo_ff[30:0], rem_sh >= {1'b0, diff_ff}};
         end
      end
      if (fire) begin
         cur_in = step_pos;
         last_in = cmd.tick_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0; tgt_ff <= '0; up_ff <= 1'b0; diff_ff <= '0;
         iv_ff <= '0; last_ff <= '0; busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         cur_ff <= cur_in; tgt_ff <= tgt_in; up_ff <= up_in; diff_ff <= diff_in;
         iv_ff <= iv_in; last_ff <= last_in; busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign stat.div_busy = busy_ff;
   assign stat.done     = (cur_in == tgt_ff) || (tgt_ff == 16'd0);
   assign stat.wrote    = fire;
   assign stat.diff     = diff_in;
   assign stat.pos      = cur_in;
endmodule
`default_nettype wire

// ----- hdl/five_axis_synchronized_ramp_top.sv -----
// Sequencing: a tick passes through the tick and output states while a move
//   runs and goes straight to the output state while idle; a move loads at
//   accept, then passes the multiply state that starts the divide, the divide
//   state until every divider is done, and the output state; a command ignored
//   while busy goes straight to the output state. Throughput: one item per
//   result taken; the per-lane radix-2 dividers dominate a move and all run at once.
// Reset: synchronous, active high; positions, targets, counters and the
//   busy flag clear and the timing registers load their default values.
`default_nettype none
module five_axis_synchronized_ramp_top
   import fasr_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 5
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [0:0]      csr_index,
   input  wire logic [15:0]     csr_wdata
);
   // The sequencer walks one item through a few phases. Only one item is in
   // flight; the response register holds the result until it is transferred.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TICK  = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [15:0]     period_ff, settle_ff;
   logic [31:0]     tick_ff, tick_in;
   logic [31:0]     start_ff, start_in;
   logic [15:0]     big_ff, big_in;
   logic            moving_ff, moving_in;
   logic [5:0]      mask_ff, mask_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     dest_arr [NUM_CHANNELS];
   lane_cmd_type    cmd;
   lane_stat_type   stat [NUM_CHANNELS];
   logic [15:0]     pos_arr [NUM_DEST];
   logic            all_done, any_div;
   logic [15:0]     big_calc;
   logic [5:0]      lane_mask;
   logic [41:0]     elapsed_q8, deadline;
   logic            req_fire;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         case (i)
            0: dest_arr[i] = req_data.dest_0;
            1: dest_arr[i] = req_data.dest_1;
            2: dest_arr[i] = req_data.dest_2;
            3: dest_arr[i] = req_data.dest_3;
            4: dest_arr[i] = req_data.dest_4;
            default: dest_arr[i] = 16'd0;
         endcase
      end
   end

   // The move and the tick are both latched at accept, so lanes see the
   // command in the same cycle that the item is transferred. The dividend is
   // formed in the multiply phase from the largest difference latched at load.
   always_comb begin
      cmd.load       = req_fire && (req_data.req_type == REQ_MOVE) && !moving_ff;
      cmd.tick       = req_fire && (req_data.req_type == REQ_TICK) && moving_ff;
      cmd.tick_count = (req_fire && req_data.req_type == REQ_TICK) ? tick_ff + 32'd1 : tick_ff;
      cmd.div_start  = (state_ff == ST_MUL);
      cmd.dividend   = {16'd0, big_ff} * {16'd0, period_ff};
   end

   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      fasr_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .dest  (dest_arr[g]),
         .stat  (stat[g])
      );
   end

   // Merge logic: largest difference, completion, divider busy, write mask, positions and deadline.
   always_comb begin
      big_calc = 16'd0;
      all_done = 1'b1;
      any_div  = 1'b0;
      lane_mask = 6'd0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (stat[i].diff > big_calc) big_calc = stat[i].diff;
         if (!stat[i].done) all_done = 1'b0;
         if (stat[i].div_busy) any_div = 1'b1;
         if (i < NUM_DEST && stat[i].wrote) begin
            lane_mask[i] = 1'b1;
            if (i == MIRROR_SRC) lane_mask[MIRROR_BIT] = 1'b1;
         end
      end
      for (int j = 0; j < NUM_DEST; j++) begin
         pos_arr[j] = (j < NUM_CHANNELS) ? stat[j].pos : 16'd0;
      end
      elapsed_q8 = {2'd0, tick_in - start_ff, 8'd0};
      deadline   = {26'd0, big_ff} * ({26'd0, period_ff} + {26'd0, settle_ff});
   end

   always_comb begin
      state_in = state_ff; tick_in = tick_ff; start_in = start_ff; big_in = big_ff;
      moving_in = moving_ff; mask_in = mask_ff; rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mask_in = 6'd0;
               if (req_data.req_type == REQ_TICK) begin
                  tick_in = tick_ff + 32'd1;
                  mask_in = lane_mask;
                  state_in = moving_ff ? ST_TICK : ST_OUT;
               end else if (!moving_ff) begin
                  start_in = tick_ff;
                  moving_in = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_TICK: begin
            // Positions are settled; check completion against the deadline.
            if (all_done && (elapsed_q8 >= deadline)) moving_in = 1'b0;
            state_in = ST_OUT;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!any_div) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (cmd.load) big_in = big_calc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         period_ff <= STEP_PERIOD_RESET;
         settle_ff <= SETTLE_EXTRA_RESET;
         tick_ff <= '0; start_ff <= '0; big_ff <= '0;
         moving_ff <= 1'b0; mask_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; tick_ff <= tick_in; start_ff <= start_in;
         big_ff <= big_in; moving_ff <= moving_in; mask_ff <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_STEP_PERIOD:  period_ff <= csr_wdata;
               CSR_SETTLE_EXTRA: settle_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_data.pos_0 = pos_arr[0];
      rsp_data.pos_1 = pos_arr[1];
      rsp_data.pos_2 = pos_arr[2];
      rsp_data.pos_3 = pos_arr[3];
      rsp_data.pos_4 = pos_arr[4];
      rsp_data.write_mask = mask_ff;
      rsp_data.busy_res = moving_ff;
   end

   // A new item is never taken while a result waits.
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall) else $error("accept while result pending");
   // The mirror bit follows channel one.
   a_mirror: assert property (@(posedge clock) disable iff (reset)
      mask_ff[MIRROR_BIT] == mask_ff[MIRROR_SRC]) else $error("mirror mismatch");
   // The block is always busy during the multiply phase of a move.
   a_move_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> moving_ff) else $error("move not busy");
   // Dividers only run during the divide phase.
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      any_div |-> (state_ff == ST_DIV)) else $error("divider out of phase");
endmodule
`default_nettype wire
